// File: rtl/core/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, constants and the acknowledge rule for the serial frame
// receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

    // longest run of bytes after the length byte before an overrun
    localparam int MAX_FRAME = 256;
    // counter holds up to MAX_FRAME + 1
    localparam int CNT_W = $clog2(MAX_FRAME + 2);

    localparam logic [7:0] START_NORMAL = 8'h04;
    localparam logic [7:0] START_DATA   = 8'h03;
    localparam logic [7:0] SEQ_MASK     = 8'h1f;
    localparam logic [7:0] SEQ_OFFSET   = 8'h08;

    // message types that are never acknowledged
    localparam logic [7:0] TYPE_0A = 8'h0a;
    localparam logic [7:0] TYPE_0C = 8'h0c;
    localparam logic [7:0] TYPE_0F = 8'h0f;
    localparam logic [7:0] TYPE_15 = 8'h15;
    localparam logic [7:0] TYPE_20 = 8'h20;
    localparam logic [7:0] TYPE_23 = 8'h23;
    localparam logic [7:0] TYPE_24 = 8'h24;
    localparam logic [7:0] TYPE_25 = 8'h25;
    localparam logic [7:0] TYPE_26 = 8'h26;
    localparam logic [7:0] TYPE_3F = 8'h3f;
    localparam logic [7:0] TYPE_4A = 8'h4a;
    localparam logic [7:0] TYPE_4C = 8'h4c;
    // acknowledged unless its length byte is the short length
    localparam logic [7:0] TYPE_27   = 8'h27;
    localparam logic [7:0] SHORT_LEN = 8'h02;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD     = 2'd2,
        KIND_OVERRUN = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [2:0]  frame_kind;
        logic [7:0]  frame_type;
        logic [7:0]  frame_length;
        logic        ack_needed;
        logic [7:0]  ack_sequence;
    } result_t;

    function automatic logic ack_due(input logic [7:0] msg_type, input logic [7:0] len);
        logic due;
        due = 1'b1;
        if (msg_type inside {TYPE_0A, TYPE_0C, TYPE_0F, TYPE_15, TYPE_20, TYPE_23,
                             TYPE_24, TYPE_25, TYPE_26, TYPE_3F, TYPE_4A, TYPE_4C})
        begin
            due = 1'b0;
        end
        else if (msg_type == TYPE_27)
        begin
            due = (len != SHORT_LEN);
        end
        return due;
    endfunction

endpackage

// File: rtl/core/sfr_in_reg.sv
// ----------------------------------------------------------------------------
// sfr_in_reg
// Input register: holds one received byte until the frame core takes it.
// ----------------------------------------------------------------------------
module sfr_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       take,
    output logic       hold_valid,
    output logic [7:0] hold_byte
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       load;

    // free when empty or when the held byte moves on this cycle
    assign in_stall   = valid_reg && !take;
    assign load       = in_valid && !in_stall;
    assign hold_valid = valid_reg;
    assign hold_byte  = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= rx_byte;
        end
    end

endmodule

// File: rtl/core/sfr_frame_core.sv
// ----------------------------------------------------------------------------
// sfr_frame_core
// Frame state machine: start hunt, length, body bytes, checksum verdict and
// acknowledge decision. Produces at most one result per byte.
// ----------------------------------------------------------------------------
module sfr_frame_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    output logic             res_valid,
    output sfr_pkg::result_t res
);

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_MSG  = 2'd2
    } phase_t;

    phase_t                    phase_reg,   phase_next;
    logic [2:0]                start_reg,   start_next;
    logic [7:0]                len_reg,     len_next;
    logic [sfr_pkg::CNT_W-1:0] seen_reg,    seen_next;
    logic [7:0]                xor_reg,     xor_next;
    logic [7:0]                first_reg,   first_next;
    logic [7:0]                second_reg,  second_next;
    logic                      ack;

    always_comb
    begin
        phase_next  = phase_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        seen_next   = seen_reg;
        xor_next    = xor_reg;
        first_next  = first_reg;
        second_next = second_reg;
        res_valid   = 1'b0;
        ack         = 1'b0;

        case (phase_reg)
            PH_LEN:
            begin
                len_next    = rx_byte;
                seen_next   = '0;
                xor_next    = xor_reg ^ rx_byte;
                first_next  = 8'h00;
                second_next = 8'h00;
                phase_next  = PH_MSG;
            end
            PH_MSG:
            begin
                seen_next = seen_reg + sfr_pkg::CNT_W'(1);
                if (seen_next == sfr_pkg::CNT_W'(1))
                begin
                    first_next = rx_byte;
                end
                else if (seen_next == sfr_pkg::CNT_W'(2))
                begin
                    second_next = rx_byte;
                end
                xor_next  = xor_reg ^ rx_byte;
                res_valid = 1'b1;
                if ((seen_next > sfr_pkg::CNT_W'(sfr_pkg::MAX_FRAME))
                    || (9'(seen_next) > {1'b0, len_reg}))
                begin
                    phase_next = PH_HUNT;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
                if (rx_byte == sfr_pkg::START_NORMAL || rx_byte == sfr_pkg::START_DATA)
                begin
                    start_next = rx_byte[2:0];
                    xor_next   = rx_byte;
                    phase_next = PH_LEN;
                end
            end
        endcase

        ack = sfr_pkg::ack_due(first_next, len_reg);

        res.kind         = sfr_pkg::KIND_PAYLOAD;
        res.data_byte    = 8'h00;
        res.frame_kind   = start_reg;
        res.frame_type   = first_next;
        res.frame_length = len_reg;
        res.ack_needed   = 1'b0;
        res.ack_sequence = 8'h00;

        // overrun takes precedence over the checksum test
        if (seen_next > sfr_pkg::CNT_W'(sfr_pkg::MAX_FRAME))
        begin
            res.kind = sfr_pkg::KIND_OVERRUN;
        end
        else if (9'(seen_next) > {1'b0, len_reg})
        begin
            if (rx_byte == xor_reg)
            begin
                res.kind       = sfr_pkg::KIND_GOOD;
                res.ack_needed = ack;
                if (ack)
                begin
                    res.ack_sequence = (second_next & sfr_pkg::SEQ_MASK)
                                       - sfr_pkg::SEQ_OFFSET;
                end
            end
            else
            begin
                res.kind = sfr_pkg::KIND_BAD;
            end
        end
        else
        begin
            res.data_byte = rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            start_reg  <= 3'd0;
            len_reg    <= 8'h00;
            seen_reg   <= '0;
            xor_reg    <= 8'h00;
            first_reg  <= 8'h00;
            second_reg <= 8'h00;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            start_reg  <= start_next;
            len_reg    <= len_next;
            seen_reg   <= seen_next;
            xor_reg    <= xor_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

endmodule

// File: rtl/core/sfr_out_reg.sv
// ----------------------------------------------------------------------------
// sfr_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module sfr_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  sfr_pkg::result_t res,
    output logic             free,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [1:0]       kind,
    output logic [7:0]       data_byte,
    output logic [2:0]       frame_kind,
    output logic [7:0]       frame_type,
    output logic [7:0]       frame_length,
    output logic             ack_needed,
    output logic [7:0]       ack_sequence
);

    logic             valid_reg;
    sfr_pkg::result_t res_reg;

    assign free         = !valid_reg || !out_stall;
    assign out_valid    = valid_reg;
    assign kind         = res_reg.kind;
    assign data_byte    = res_reg.data_byte;
    assign frame_kind   = res_reg.frame_kind;
    assign frame_type   = res_reg.frame_type;
    assign frame_length = res_reg.frame_length;
    assign ack_needed   = res_reg.ack_needed;
    assign ack_sequence = res_reg.ack_sequence;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            res_reg <= res;
        end
    end

endmodule

// File: rtl/core/serial_frame_receiver_with_ack_unit.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver_with_ack_unit
// Framed byte receiver with checksum verdict and acknowledge decision.
// ----------------------------------------------------------------------------
// path: a byte is held in the input register, and its result is then held in the
//   result register, which drives the outputs
// throughput: one byte per cycle; the input holds only while the result
//   register is full and stalled
// reset: asynchronous, returns to start-byte hunt with all frame state cleared
// ----------------------------------------------------------------------------
module serial_frame_receiver_with_ack_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] data_byte,
    output logic [2:0] frame_kind,
    output logic [7:0] frame_type,
    output logic [7:0] frame_length,
    output logic       ack_needed,
    output logic [7:0] ack_sequence
);

    logic             hold_valid;
    logic [7:0]       hold_byte;
    logic             out_free;
    logic             step;
    logic             res_valid;
    sfr_pkg::result_t res;

    // a held byte moves on whenever the result register can take a result
    assign step = hold_valid && out_free;

    sfr_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .take       (step),
        .hold_valid (hold_valid),
        .hold_byte  (hold_byte)
    );

    sfr_frame_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (hold_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    sfr_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (step && res_valid),
        .res          (res),
        .free         (out_free),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .data_byte    (data_byte),
        .frame_kind   (frame_kind),
        .frame_type   (frame_type),
        .frame_length (frame_length),
        .ack_needed   (ack_needed),
        .ack_sequence (ack_sequence)
    );

    // a new result only follows a core step
    a_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(step))
        else $error("result appeared without a core step");

    // the core never steps into a full, stalled result register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(step && out_valid && out_stall))
        else $error("core stepped while result register was blocked");

    // acknowledge only on a good frame
    a_ack_good_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ack_needed) |-> (kind == sfr_pkg::KIND_GOOD))
        else $error("acknowledge flagged on a non-good result");

endmodule

// File: tb/sv/sfr_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sfr_frame_checker
// Watches both channels of the serial frame receiver, tracks the framing
// state of the byte stream on its own and compares every result transfer,
// field by field, with the oldest predicted result.
// ----------------------------------------------------------------------------
module sfr_frame_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [1:0] kind,
    input  logic [7:0] data_byte,
    input  logic [2:0] frame_kind,
    input  logic [7:0] frame_type,
    input  logic [7:0] frame_length,
    input  logic       ack_needed,
    input  logic [7:0] ack_sequence,
    output int         errors,
    output int         pending
);

    typedef enum logic [1:0] {
        HUNT    = 2'd0,
        GET_LEN = 2'd1,
        IN_MSG  = 2'd2
    } framing_t;

    framing_t                  phase;
    logic [2:0]                start_kind;
    logic [7:0]                body_len;
    logic [sfr_pkg::CNT_W-1:0] seen;
    logic [7:0]                xor_acc;
    logic [7:0]                type_byte;
    logic [7:0]                seq_byte;
    sfr_pkg::result_t          frame_results_q[$];

    function automatic logic wants_ack(input logic [7:0] msg_type, input logic [7:0] len);
        case (msg_type)
            sfr_pkg::TYPE_0A, sfr_pkg::TYPE_0C, sfr_pkg::TYPE_0F, sfr_pkg::TYPE_15,
            sfr_pkg::TYPE_20, sfr_pkg::TYPE_23, sfr_pkg::TYPE_24, sfr_pkg::TYPE_25,
            sfr_pkg::TYPE_26, sfr_pkg::TYPE_3F, sfr_pkg::TYPE_4A, sfr_pkg::TYPE_4C:
                return 1'b0;
            sfr_pkg::TYPE_27:
                return len != sfr_pkg::SHORT_LEN;
            default:
                return 1'b1;
        endcase
    endfunction

    task automatic track_byte(input logic [7:0] b);
        sfr_pkg::result_t r;
        logic             ack;
        r = '0;
        case (phase)
            GET_LEN:
            begin
                body_len  = b;
                seen      = '0;
                xor_acc   = xor_acc ^ b;
                type_byte = 8'h00;
                seq_byte  = 8'h00;
                phase     = IN_MSG;
            end
            IN_MSG:
            begin
                seen = seen + 1'b1;
                if (seen == 1)
                    type_byte = b;
                else if (seen == 2)
                    seq_byte = b;
                r.frame_kind   = start_kind;
                r.frame_type   = type_byte;
                r.frame_length = body_len;
                if (seen > sfr_pkg::MAX_FRAME)
                begin
                    r.kind = sfr_pkg::KIND_OVERRUN;
                    phase  = HUNT;
                end
                else if (seen > body_len)
                begin
                    // checksum byte closes the frame
                    if (b == xor_acc)
                    begin
                        ack          = wants_ack(type_byte, body_len);
                        r.kind       = sfr_pkg::KIND_GOOD;
                        r.ack_needed = ack;
                        if (ack)
                            r.ack_sequence = (seq_byte & sfr_pkg::SEQ_MASK)
                                             - sfr_pkg::SEQ_OFFSET;
                    end
                    else
                    begin
                        r.kind = sfr_pkg::KIND_BAD;
                    end
                    phase = HUNT;
                end
                else
                begin
                    r.kind      = sfr_pkg::KIND_PAYLOAD;
                    r.data_byte = b;
                end
                xor_acc = xor_acc ^ b;
                frame_results_q.push_back(r);
            end
            default:
            begin
                phase = HUNT;
                if (b == sfr_pkg::START_NORMAL || b == sfr_pkg::START_DATA)
                begin
                    start_kind = b[2:0];
                    xor_acc    = b;
                    phase      = GET_LEN;
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    task automatic check_result();
        sfr_pkg::result_t want;
        if (frame_results_q.size() == 0)
        begin
            errors++;
            $display("%0t ns: unexpected result, expected none, actual kind %0d data %h",
                     $time, kind, data_byte);
        end
        else
        begin
            want = frame_results_q.pop_front();
            check_field("kind", 8'(want.kind), 8'(kind));
            check_field("data_byte", want.data_byte, data_byte);
            check_field("frame_kind", 8'(want.frame_kind), 8'(frame_kind));
            check_field("frame_type", want.frame_type, frame_type);
            check_field("frame_length", want.frame_length, frame_length);
            check_field("ack_needed", 8'(want.ack_needed), 8'(ack_needed));
            check_field("ack_sequence", want.ack_sequence, ack_sequence);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            errors     = 0;
            phase      = HUNT;
            start_kind = '0;
            body_len   = '0;
            seen       = '0;
            xor_acc    = '0;
            type_byte  = '0;
            seq_byte   = '0;
            frame_results_q.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                track_byte(rx_byte);
            if (out_valid && !out_stall)
                check_result();
        end
        pending = frame_results_q.size();
    end

endmodule

// File: tb/sv/serial_frame_receiver_with_ack_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_frame_receiver_with_ack_unit_test
// Drives framed byte streams into the serial frame receiver: a short set of
// hand-built frames, then random frames with noise, bad checksums and cut
// frames, under random sender bursts and receiver stalls. Checking is done
// by the frame checker that sits beside the block.
// ----------------------------------------------------------------------------
module serial_frame_receiver_with_ack_unit_test;

    localparam int N_ITEMS = 1650;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [2:0] frame_kind;
    logic [7:0] frame_type;
    logic [7:0] frame_length;
    logic       ack_needed;
    logic [7:0] ack_sequence;
    int         errors;
    int         pending;

    logic [7:0] body_q[$];
    int         burst_left  = 0;
    int         sent_items  = 0;
    int         stall_mode  = 0;
    int         mode_left   = 0;
    int         stall_phase = 0;

    logic [7:0] quiet_types[13] = '{sfr_pkg::TYPE_0A, sfr_pkg::TYPE_0C, sfr_pkg::TYPE_0F,
                                    sfr_pkg::TYPE_15, sfr_pkg::TYPE_20, sfr_pkg::TYPE_23,
                                    sfr_pkg::TYPE_24, sfr_pkg::TYPE_25, sfr_pkg::TYPE_26,
                                    sfr_pkg::TYPE_3F, sfr_pkg::TYPE_4A, sfr_pkg::TYPE_4C,
                                    sfr_pkg::TYPE_27};

    serial_frame_receiver_with_ack_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .data_byte    (data_byte),
        .frame_kind   (frame_kind),
        .frame_type   (frame_type),
        .frame_length (frame_length),
        .ack_needed   (ack_needed),
        .ack_sequence (ack_sequence)
    );

    sfr_frame_checker frame_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .data_byte    (data_byte),
        .frame_kind   (frame_kind),
        .frame_type   (frame_type),
        .frame_length (frame_length),
        .ack_needed   (ack_needed),
        .ack_sequence (ack_sequence),
        .errors       (errors),
        .pending      (pending)
    );

    always #6 clk = ~clk;

    // receiver: free-running, random, or a fixed stall pattern
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 200);
        end
        mode_left--;
        stall_phase = (stall_phase + 1) % 5;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= (stall_phase < 3);
        endcase
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic put_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                rx_byte  <= 8'($urandom_range(0, 255));
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
        end
        burst_left--;
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // sends start, length, random-padded body, checksum; maybe bad or cut
    task automatic put_frame(input logic [7:0] start_b, input logic [7:0] len,
                             input bit corrupt, input bit cut);
        logic [7:0] csum;
        logic [7:0] frame_q[$];
        int         n;
        while (body_q.size() < len)
            body_q.push_back(8'($urandom_range(0, 255)));
        csum = start_b ^ len;
        frame_q.push_back(start_b);
        frame_q.push_back(len);
        for (int i = 0; i < len; i++)
        begin
            csum = csum ^ body_q[i];
            frame_q.push_back(body_q[i]);
        end
        if (corrupt)
            csum = csum ^ 8'($urandom_range(1, 255));
        frame_q.push_back(csum);
        n = cut ? $urandom_range(1, frame_q.size() - 1) : frame_q.size();
        for (int i = 0; i < n; i++)
            put_byte(frame_q[i]);
        sent_items += n;
        body_q.delete();
    endtask

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        logic [7:0] len;
        logic [7:0] start_b;
        int         big_frames;
        int         frames;
        bit         drained;

        big_frames = 0;
        frames     = 0;
        drained    = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // hand-built frames: ignored byte, empty frames, one-byte body,
        // short type 0x27, long type 0x27, unacknowledged type
        put_byte(8'h5a);
        put_frame(sfr_pkg::START_NORMAL, 8'd0, 1'b0, 1'b0);
        put_frame(sfr_pkg::START_DATA, 8'd0, 1'b1, 1'b0);
        body_q = '{8'hff};
        put_frame(sfr_pkg::START_DATA, 8'd1, 1'b0, 1'b0);
        body_q = '{sfr_pkg::TYPE_27, 8'h55};
        put_frame(sfr_pkg::START_NORMAL, sfr_pkg::SHORT_LEN, 1'b0, 1'b0);
        body_q = '{sfr_pkg::TYPE_27, 8'h1f, 8'h00};
        put_frame(sfr_pkg::START_DATA, 8'd3, 1'b0, 1'b0);
        body_q = '{sfr_pkg::TYPE_4C, 8'h00};
        put_frame(sfr_pkg::START_NORMAL, 8'd2, 1'b0, 1'b0);
        sent_items = 0;

        while (sent_items < N_ITEMS)
        begin
            // line noise between frames, may itself open a frame
            if ($urandom_range(0, 99) < 15)
                repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));

            if (frames == 0 || (big_frames < 2 && $urandom_range(0, 99) == 0))
            begin
                len = 8'd255;
                big_frames++;
            end
            else if ($urandom_range(0, 9) == 0)
                len = 8'($urandom_range(9, 40));
            else
                len = 8'($urandom_range(0, 8));

            if (len != 0 && $urandom_range(0, 9) < 4)
            begin
                body_q.push_back(quiet_types[4'($urandom_range(0, 12))]);
                if (body_q[0] == sfr_pkg::TYPE_27 && $urandom_range(0, 1) == 1)
                    len = sfr_pkg::SHORT_LEN;
            end

            start_b = $urandom_range(0, 1) ? sfr_pkg::START_NORMAL : sfr_pkg::START_DATA;
            put_frame(start_b, len, $urandom_range(0, 9) == 0, $urandom_range(0, 24) == 0);
            frames++;

            // hold off until the block has handed over everything
            if (!drained && sent_items >= N_ITEMS / 2)
            begin
                drained = 1;
                in_valid <= 1'b0;
                wait (pending == 0);
                @(negedge clk);
            end
        end

        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
